[hw/rtl/rdcc_pkg.sv]
// Shared types, status codes and the CRC-32 byte step for the record deframer.
`timescale 1ns / 1ps
`default_nettype none

package rdcc_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [31:0] CRC_POLY       = 32'hEDB8_8320;
  localparam logic [31:0] CRC_START_RST  = 32'hFFFF_FFFF;
  localparam logic [7:0]  RECORD_MARK_RST = 8'd93;

  // Configuration register indexes
  localparam logic CFG_CRC_START   = 1'b0;
  localparam logic CFG_RECORD_MARK = 1'b1;

  // Status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BEGIN   = 3'd1;
  localparam logic [2:0] ST_END     = 3'd2;
  localparam logic [2:0] ST_BADREC  = 3'd3;
  localparam logic [2:0] ST_BADSIZE = 3'd4;
  localparam logic [2:0] ST_CRCERR  = 3'd5;
  localparam logic [2:0] ST_EOD     = 3'd6;

  // Descriptor type field (flags bits 1..0)
  localparam logic [1:0] TYPE_INVALID = 2'd0;
  localparam logic [1:0] TYPE_RECORD  = 2'd1;
  localparam logic [1:0] TYPE_BEGIN   = 2'd2;
  localparam logic [1:0] TYPE_END     = 2'd3;

  // Descriptor byte positions
  localparam logic [2:0] HDR_SIG    = 3'd0;
  localparam logic [2:0] HDR_FLAGS  = 3'd1;
  localparam logic [2:0] HDR_LEN0   = 3'd2;
  localparam logic [2:0] HDR_LEN1   = 3'd3;
  localparam logic [2:0] HDR_CRC0   = 3'd4;
  localparam logic [2:0] HDR_CRC1   = 3'd5;
  localparam logic [2:0] HDR_CRC2   = 3'd6;
  localparam logic [2:0] HDR_CRC3   = 3'd7;

  typedef struct packed {
    logic       is_status;
    logic [7:0] payload_out;
    logic [2:0] status_code;
    logic       last;
  } result_t;

  // Reflected CRC-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] v;
    v = {24'd0, crc[7:0] ^ b};
    for (int i = 0; i < 8; i++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return (crc >> 8) ^ v;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/record_deframer_crc32_check.sv]
// Top level of the record deframer with CRC-32 payload check.
`timescale 1ns / 1ps
`default_nettype none

// Takes one stream byte per cycle. Each record is an 8-byte little-endian
// descriptor (signature, flags, 16-bit size, 32-bit CRC) followed by its
// payload; payload bytes come out as data results, and descriptor outcomes,
// payload end and stream end come out as status results with last set. A
// byte goes through an input register and one pass of parse/CRC logic into
// a four-entry result queue, so a result passes both the input register and
// the queue before it appears. Throughput is one byte per cycle; the last byte
// of a payload yields two results, and the input stalls while the queue has
// fewer than two free entries. cfg_ready is always high; write configuration
// only while the block is idle.
module record_deframer_crc32_check
  import rdcc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic [15:0] in_expected_size,
  input  wire logic        in_stream_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_is_status,
  output logic [7:0]       out_payload_out,
  output logic [2:0]       out_status_code,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic    q_room;
  logic    push_one;
  logic    push_two;
  result_t res_a;
  result_t res_b;
  result_t head;

  assign cfg_ready = 1'b1;

  rdcc_parser u_parser (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_expected_size (in_expected_size),
    .in_stream_end    (in_stream_end),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .q_room           (q_room),
    .push_one         (push_one),
    .push_two         (push_two),
    .res_a            (res_a),
    .res_b            (res_b)
  );

  rdcc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_one  (push_one),
    .push_two  (push_two),
    .res_a     (res_a),
    .res_b     (res_b),
    .room      (q_room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_is_status   = head.is_status;
  assign out_payload_out = head.payload_out;
  assign out_status_code = head.status_code;
  assign out_last        = head.last;

endmodule

`default_nettype wire

[hw/rtl/rdcc_parser.sv]
// Input register, descriptor parser, payload CRC and configuration registers.
`timescale 1ns / 1ps
`default_nettype none

module rdcc_parser
  import rdcc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic [15:0] in_expected_size,
  input  wire logic        in_stream_end,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        q_room,
  output logic             push_one,
  output logic             push_two,
  output result_t          res_a,
  output result_t          res_b
);

  typedef enum logic {PH_HEADER, PH_PAYLOAD} phase_t;

  logic        vld_r;
  logic [7:0]  byte_r;
  logic [15:0] want_r;
  logic        ends_r;

  logic [31:0] crc_start_r;
  logic [7:0]  mark_r;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  hidx_r, hidx_nxt;
  logic [2:0]  flags_r, flags_nxt;
  logic [7:0]  sig_r, sig_nxt;
  logic [15:0] len_r, len_nxt;
  logic [31:0] stored_r, stored_nxt;
  logic [31:0] run_r, run_nxt;
  logic [15:0] left_r, left_nxt;

  logic        accept;
  logic        proc;
  logic [31:0] crc_upd;
  logic [15:0] left_dec;

  assign proc     = vld_r && q_room;
  assign in_stall = vld_r && !q_room;
  assign accept   = in_valid && !in_stall;
  assign crc_upd  = crc_byte(run_r, byte_r);
  assign left_dec = left_r - 16'd1;

  always_comb begin
    phase_nxt  = phase_r;
    hidx_nxt   = hidx_r;
    flags_nxt  = flags_r;
    sig_nxt    = sig_r;
    len_nxt    = len_r;
    stored_nxt = stored_r;
    run_nxt    = run_r;
    left_nxt   = left_r;
    push_one   = 1'b0;
    push_two   = 1'b0;
    res_a      = '{is_status: 1'b1, payload_out: 8'd0, status_code: ST_OK, last: 1'b1};
    res_b      = '{is_status: 1'b1, payload_out: 8'd0, status_code: ST_OK, last: 1'b1};

    if (proc) begin
      if (ends_r) begin
        phase_nxt         = PH_HEADER;
        hidx_nxt          = HDR_SIG;
        push_one          = 1'b1;
        res_a.status_code = ST_EOD;
      end else if (phase_r == PH_PAYLOAD) begin
        run_nxt  = crc_upd;
        left_nxt = left_dec;
        res_a    = '{is_status: 1'b0, payload_out: byte_r, status_code: ST_OK, last: 1'b0};
        if (left_dec == 16'd0) begin
          phase_nxt = PH_HEADER;
          hidx_nxt  = HDR_SIG;
          push_two  = 1'b1;
          if (flags_r[2] && (~crc_upd != stored_r)) begin
            res_b.status_code = ST_CRCERR;
          end
        end else begin
          push_one = 1'b1;
        end
      end else begin
        case (hidx_r)
          HDR_SIG:   sig_nxt    = byte_r;
          HDR_FLAGS: flags_nxt  = byte_r[2:0];
          HDR_LEN0:  len_nxt    = {8'd0, byte_r};
          HDR_LEN1:  len_nxt    = {byte_r, len_r[7:0]};
          HDR_CRC0:  stored_nxt = {24'd0, byte_r};
          HDR_CRC1:  stored_nxt = {16'd0, byte_r, stored_r[7:0]};
          HDR_CRC2:  stored_nxt = {8'd0, byte_r, stored_r[15:0]};
          default:   stored_nxt = {byte_r, stored_r[23:0]};
        endcase
        hidx_nxt = hidx_r + 3'd1;
        // last descriptor byte: decide using fields gathered so far
        if (hidx_r == HDR_CRC3) begin
          push_one = 1'b1;
          if (sig_r != mark_r) begin
            res_a.status_code = ST_BADREC;
          end else begin
            case (flags_r[1:0])
              TYPE_BEGIN:   res_a.status_code = ST_BEGIN;
              TYPE_END:     res_a.status_code = ST_END;
              TYPE_RECORD: begin
                if (want_r == 16'd0) begin
                  res_a.status_code = ST_BADREC;
                end else if (len_r != want_r) begin
                  res_a.status_code = ST_BADSIZE;
                end else begin
                  push_one  = 1'b0;
                  phase_nxt = PH_PAYLOAD;
                  left_nxt  = len_r;
                  run_nxt   = crc_start_r;
                end
              end
              default:      res_a.status_code = ST_BADREC;
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= 1'b0;
      crc_start_r <= CRC_START_RST;
      mark_r      <= RECORD_MARK_RST;
      phase_r     <= PH_HEADER;
      hidx_r      <= HDR_SIG;
      flags_r     <= 3'd0;
      sig_r       <= 8'd0;
      len_r       <= 16'd0;
      stored_r    <= 32'd0;
      run_r       <= CRC_START_RST;
      left_r      <= 16'd0;
    end else begin
      if (accept) begin
        vld_r <= 1'b1;
      end else if (proc) begin
        vld_r <= 1'b0;
      end
      if (cfg_valid) begin
        if (cfg_index == CFG_CRC_START) begin
          crc_start_r <= cfg_data;
        end else begin
          mark_r <= cfg_data[7:0];
        end
      end
      phase_r  <= phase_nxt;
      hidx_r   <= hidx_nxt;
      flags_r  <= flags_nxt;
      sig_r    <= sig_nxt;
      len_r    <= len_nxt;
      stored_r <= stored_nxt;
      run_r    <= run_nxt;
      left_r   <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_data_byte;
      want_r <= in_expected_size;
      ends_r <= in_stream_end;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/rdcc_queue.sv]
// Small result queue: takes up to two results per cycle, delivers one while out_stall is low.
`timescale 1ns / 1ps
`default_nettype none

module rdcc_queue
  import rdcc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_one,
  input  wire logic push_two,
  input  result_t   res_a,
  input  result_t   res_b,
  output logic      room,
  output logic      out_valid,
  input  wire logic out_stall,
  output result_t   head
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  result_t       mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pop;
  logic [PW-1:0] wr_p1;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && !out_stall;
  assign room      = (cnt_r <= CW'(QUEUE_DEPTH - 2));
  assign head      = mem_r[rd_r];
  assign wr_p1     = wr_r + PW'(1);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push_two) begin
      cnt_nxt = cnt_nxt + CW'(2);
    end else if (push_one) begin
      cnt_nxt = cnt_nxt + CW'(1);
    end
    if (pop) begin
      cnt_nxt = cnt_nxt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (pop) begin
        rd_r <= rd_r + PW'(1);
      end
      if (push_two) begin
        wr_r <= wr_r + PW'(2);
      end else if (push_one) begin
        wr_r <= wr_p1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_one || push_two) begin
      mem_r[wr_r] <= res_a;
    end
    if (push_two) begin
      mem_r[wr_p1] <= res_b;
    end
  end

endmodule

`default_nettype wire
